// ===== design/mre_pkg.sv =====
`default_nettype none
package mre_pkg;

  localparam int unsigned REPORT_MAX_BYTES = 19;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CELL_W = 14;
  localparam int unsigned CODE_W = 7;
  localparam int unsigned REPORT_CODE_W = 8;
  localparam int unsigned LEN_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HBORDER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VBORDER = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_W = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_H = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_W = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_H = 3'd6;

  localparam logic [1:0] CMD_PRESS = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MOTION = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [CODE_W-1:0] CODE_NONE_HELD = 7'd3;
  localparam logic [7:0] ESC_BYTE = 8'h1b;

  // One classified report, handed from the front to the back.
  typedef struct packed {
    logic                     sgr;
    logic                     release_ev;
    logic [REPORT_CODE_W-1:0] code;
    logic [CELL_W-1:0]        col;
    logic [CELL_W-1:0]        row;
  } job_t;

endpackage
`default_nettype wire

// ===== design/mre_if.sv =====
`default_nettype none
interface mre_in_if (input wire logic clk);
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] pointer_x;
  logic signed [15:0] pointer_y;
  logic [3:0]        button_number;
  logic              shift_held;
  logic              super_held;
  logic              control_held;
  modport source (output valid, cmd, pointer_x, pointer_y, button_number, shift_held,
                  super_held, control_held, input ready);
  modport sink (input valid, cmd, pointer_x, pointer_y, button_number, shift_held,
                super_held, control_held, output ready);
endinterface

interface mre_out_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;
  modport source (output valid, report_byte, last_byte, input ready);
  modport sink (input valid, report_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== design/mre_front.sv =====
`default_nettype none
module mre_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mre_in_if.sink                                 in_ch,
  input  wire logic [3:0]                        report_mode,
  input  wire logic [11:0]                       horizontal_border,
  input  wire logic [11:0]                       vertical_border,
  input  wire logic [13:0]                       text_width,
  input  wire logic [13:0]                       text_height,
  input  wire logic [7:0]                        cell_width,
  input  wire logic [7:0]                        cell_height,
  output      logic                              job_valid,
  input  wire logic                              job_ready,
  output      mre_pkg::job_t                     job
);
  import mre_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DECIDE, S_PUSH} state_t;
  state_t state;

  logic [1:0] cmd;
  logic [3:0] bn;
  logic [2:0] mods;
  logic [13:0] qx, qy;
  logic [14:0] rx, ry;
  logic [3:0] step;
  logic [CODE_W-1:0] held;
  logic [CELL_W-1:0] last_col, last_row;

  function automatic logic [13:0] clampc(input logic signed [15:0] p, input logic [11:0] b,
                                         input logic [13:0] lim);
    logic signed [17:0] d;
    logic signed [17:0] l;
    begin
      d = 18'(p) - $signed({6'd0, b});
      l = (lim == 14'd0) ? 18'sd0 : $signed({4'd0, lim}) - 18'sd1;
      if (d < 0) d = 0;
      if (d > l) d = l;
      clampc = d[13:0];
    end
  endfunction

  logic [7:0] dx, dy;
  assign dx = (cell_width == 8'd0) ? 8'd1 : cell_width;
  assign dy = (cell_height == 8'd0) ? 8'd1 : cell_height;

  logic [14:0] rx_sh, ry_sh;
  assign rx_sh = {rx[13:0], qx[13]};
  assign ry_sh = {ry[13:0], qy[13]};

  logic [CODE_W-1:0] press_code;
  logic [REPORT_CODE_W-1:0] code_base, code_fin;
  logic keep;
  logic move_ok;
  always_comb begin
    press_code = (bn == 4'd0) ? 7'd0 : 7'(bn - 4'd1);
    if (press_code >= 7'd3) press_code = press_code + 7'd61;
    keep = 1'b1;
    move_ok = 1'b1;
    code_base = {1'b0, press_code};
    if (cmd == CMD_MOTION) begin
      code_base = {1'b0, held} + 8'd32;
      if (qx == last_col && qy == last_row) move_ok = 1'b0;
      if (!report_mode[0] && !report_mode[1]) move_ok = 1'b0;
      if (report_mode[0] && held == CODE_NONE_HELD) move_ok = 1'b0;
      keep = move_ok;
    end else if (cmd == CMD_RELEASE) begin
      if (!report_mode[2]) code_base = {1'b0, CODE_NONE_HELD};
      if (report_mode[3]) keep = 1'b0;
      if (code_base == 8'd64 || code_base == 8'd65) keep = 1'b0;
    end
    code_fin = code_base;
    if (!report_mode[3]) code_fin = code_base + {3'd0, mods[2], mods[1], mods[0], 2'd0};
    if (!report_mode[2] && (qx >= 14'd223 || qy >= 14'd223)) keep = 1'b0;
  end

  assign in_ch.ready = (state == S_IDLE);
  assign job_valid = (state == S_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held <= CODE_NONE_HELD;
      last_col <= '0;
      last_row <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cmd <= in_ch.cmd;
          bn <= in_ch.button_number;
          mods <= {in_ch.control_held, in_ch.super_held, in_ch.shift_held};
          qx <= clampc(in_ch.pointer_x, horizontal_border, text_width);
          qy <= clampc(in_ch.pointer_y, vertical_border, text_height);
          rx <= '0;
          ry <= '0;
          step <= '0;
          if (in_ch.cmd != CMD_NONE) state <= S_DIV;
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          if (rx_sh >= {7'd0, dx}) begin
            rx <= rx_sh - {7'd0, dx};
            qx <= {qx[12:0], 1'b1};
          end else begin
            rx <= rx_sh;
            qx <= {qx[12:0], 1'b0};
          end
          if (ry_sh >= {7'd0, dy}) begin
            ry <= ry_sh - {7'd0, dy};
            qy <= {qy[12:0], 1'b1};
          end else begin
            ry <= ry_sh;
            qy <= {qy[12:0], 1'b0};
          end
          step <= step + 4'd1;
          if (step == 4'd13) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (cmd == CMD_PRESS) begin
            held <= press_code;
            last_col <= qx;
            last_row <= qy;
          end else if (cmd == CMD_RELEASE) begin
            held <= CODE_NONE_HELD;
          end else if (move_ok) begin
            // motion tracks the cell even when the legacy form drops the report
            last_col <= qx;
            last_row <= qy;
          end
          job.sgr <= report_mode[2];
          job.release_ev <= (cmd == CMD_RELEASE);
          job.code <= code_fin;
          job.col <= qx;
          job.row <= qy;
          state <= keep ? S_PUSH : S_IDLE;
        end
        S_PUSH: if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_valid |-> !in_ch.ready)
    else $error("front takes item while job pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_DECIDE))
    else $error("divider left early");
  assert property (@(posedge clk) disable iff (rst) (job_valid && !job_ready) |=> job_valid)
    else $error("job dropped");
endmodule
`default_nettype wire

// ===== design/mre_queue.sv =====
`default_nettype none
module mre_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output      logic          wr_ready,
  input  wire mre_pkg::job_t wr_job,
  output      logic          rd_valid,
  input  wire logic          rd_ready,
  output      mre_pkg::job_t rd_job
);
  import mre_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (wr_valid && wr_ready && !(rd_valid && rd_ready)) |=> rd_valid)
    else $error("queue lost write");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> (wp == rp))
    else $error("queue pointers out of step");
endmodule
`default_nettype wire

// ===== design/mre_back.sv =====
`default_nettype none
module mre_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output      logic          job_ready,
  input  wire mre_pkg::job_t job,
  mre_out_if.source          out_ch
);
  import mre_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CVT, S_LOAD, S_SEND} state_t;
  state_t state;

  logic [7:0] buf_q [REPORT_MAX_BYTES];
  logic [LEN_W-1:0] len, idx;
  logic job_rel;

  // decimal conversion of three values, one digit a cycle via reciprocal
  logic [CELL_W:0] val [3];
  logic [3:0] dig [3][5];
  logic [2:0] nd [3];
  logic [1:0] vsel;
  logic [CELL_W:0] cur, quo;
  logic [CELL_W+15:0] prod;
  logic [3:0] rem;
  logic [CELL_W:0] rem_w;

  assign cur = val[vsel];
  assign prod = {15'd0, cur} * 30'd52429;
  assign quo = 15'(prod >> 19);
  assign rem_w = cur - 15'(quo * 15'd10);
  assign rem = rem_w[3:0];

  assign job_ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_SEND);
  assign out_ch.report_byte = buf_q[idx];
  assign out_ch.last_byte = (idx == len - 5'd1);

  always_ff @(posedge clk) begin
    logic [LEN_W-1:0] n;
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      len <= '0;
      vsel <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          val[0] <= {7'd0, job.code};
          val[1] <= 15'(job.col) + 15'd1;
          val[2] <= 15'(job.row) + 15'd1;
          nd[0] <= '0;
          nd[1] <= '0;
          nd[2] <= '0;
          vsel <= '0;
          if (job.sgr) state <= S_CVT;
          else begin
            buf_q[0] <= ESC_BYTE;
            buf_q[1] <= 8'h5b;
            buf_q[2] <= 8'h4d;
            buf_q[3] <= 8'd32 + job.code;
            buf_q[4] <= 8'(job.col + 14'd33);
            buf_q[5] <= 8'(job.row + 14'd33);
            len <= 5'd6;
            idx <= '0;
            state <= S_SEND;
          end
        end
        S_CVT: begin
          dig[vsel][nd[vsel]] <= rem;
          nd[vsel] <= nd[vsel] + 3'd1;
          val[vsel] <= quo;
          if (quo == '0) begin
            if (vsel == 2'd2) state <= S_LOAD;
            else vsel <= vsel + 2'd1;
          end
        end
        S_LOAD: begin
          n = 5'd3;
          buf_q[0] <= ESC_BYTE;
          buf_q[1] <= 8'h5b;
          buf_q[2] <= 8'h3c;
          for (int v = 0; v < 3; v++) begin
            for (int k = 4; k >= 0; k--) begin
              if (3'(k) < nd[v]) begin
                buf_q[n] <= {4'h3, dig[v][k]};
                n = n + 5'd1;
              end
            end
            if (v < 2) buf_q[n] <= 8'h3b;
            else buf_q[n] <= job_rel ? 8'h6d : 8'h4d;
            n = n + 5'd1;
          end
          len <= n;
          idx <= '0;
          state <= S_SEND;
        end
        S_SEND: if (out_ch.ready) begin
          if (idx == len - 5'd1) state <= S_IDLE;
          else idx <= idx + 5'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) job_rel <= job.release_ev;
  end

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> (idx < len))
    else $error("byte index past report");
  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !job_ready)
    else $error("back takes job while sending");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_byte) |=> job_ready)
    else $error("back did not return after last byte");
endmodule
`default_nettype wire

// ===== design/mouse_report_encoder_unit.sv =====
`default_nettype none
// Pointer event to terminal mouse-report encoder.
// Channels: in_ch takes one pointer event per item (cmd, pointer_x/y, button_number,
// modifiers); out_ch returns the report one byte per item, last_byte on the final one.
// Configuration: write cfg_we with cfg_index 0..6 (mode, borders, text size, cell
// size) while idle; no read-back.
// Front: clamps the position, then divides by the cell size with two restoring
// dividers side by side, one quotient bit a cycle, and decides whether the event
// reports; it takes no new event until the last one is pushed or dropped. Front
// state (held button, last cell) updates there.
// A two-entry queue parts front and back so each side stalls on its own.
// Back: legacy reports load at once; SGR reports convert three numbers to
// decimal one digit a cycle (up to 13 digits), then pass a load state; bytes
// leave one a cycle while the receiver is ready.
// Reset: registers take their defaults, no button held, last cell zero, queue empty.
// A stalled receiver holds the current byte; the queue then fills and the front
// stops accepting events.
module mouse_report_encoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mre_in_if.sink                             in_ch,
  mre_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mre_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mre_pkg::*;

  logic [3:0] report_mode;
  logic [11:0] horizontal_border, vertical_border;
  logic [13:0] text_width, text_height;
  logic [7:0] cell_width, cell_height;

  // hold register values; write at the given index
  always_ff @(posedge clk) begin
    if (rst) begin
      report_mode <= 4'd0;
      horizontal_border <= 12'd2;
      vertical_border <= 12'd2;
      text_width <= 14'd640;
      text_height <= 14'd480;
      cell_width <= 8'd8;
      cell_height <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPORT_MODE: report_mode <= cfg_data[3:0];
        REG_HBORDER: horizontal_border <= cfg_data[11:0];
        REG_VBORDER: vertical_border <= cfg_data[11:0];
        REG_TEXT_W: text_width <= cfg_data;
        REG_TEXT_H: text_height <= cfg_data;
        REG_CELL_W: cell_width <= cfg_data[7:0];
        REG_CELL_H: cell_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  mre_front u_front (
    .clk, .rst, .in_ch,
    .report_mode, .horizontal_border, .vertical_border,
    .text_width, .text_height, .cell_width, .cell_height,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  mre_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  mre_back u_back (
    .clk, .rst,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_ch
  );

  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.report_byte))
    else $error("byte changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("byte withdrawn under stall");
  // the unused command is taken and dropped without leaving idle
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.cmd != CMD_NONE) |=> !in_ch.ready)
    else $error("front accepted twice in a row");
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import mre_pkg::*;

  // One pointer event as it crosses the input channel.
  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         bn;
    logic               sh;
    logic               su;
    logic               ct;
  } pointer_ev_t;

  // Report bytes still owed by the block, each with its last-byte flag.
  class report_scoreboard;
    logic [7:0]  owed_byte[$];
    logic        owed_last[$];
    int unsigned errors;
    // Mirror of the block's registers and tracking state.
    logic [3:0]  mode;
    logic [11:0] hborder, vborder;
    logic [13:0] text_w, text_h;
    logic [7:0]  cell_w, cell_h;
    logic [6:0]  held_code;
    logic [13:0] last_col, last_row;

    function new();
      mode = 4'd0;
      hborder = 12'd2;
      vborder = 12'd2;
      text_w = 14'd640;
      text_h = 14'd480;
      cell_w = 8'd8;
      cell_h = 8'd16;
      held_code = CODE_NONE_HELD;
      last_col = '0;
      last_row = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_REPORT_MODE: mode = val[3:0];
        REG_HBORDER:     hborder = val[11:0];
        REG_VBORDER:     vborder = val[11:0];
        REG_TEXT_W:      text_w = val[13:0];
        REG_TEXT_H:      text_h = val[13:0];
        REG_CELL_W:      cell_w = val[7:0];
        REG_CELL_H:      cell_h = val[7:0];
        default: ;
      endcase
    endfunction

    // Subtract the border, clamp into the text area, divide by the cell size.
    function int unsigned pixel_to_cell(logic signed [15:0] pos, int border, int limit,
                                        int unsigned cs);
      int p;
      int lim;
      p = int'(pos) - border;
      lim = (limit == 0) ? 0 : limit - 1;
      if (p < 0) p = 0;
      if (p > lim) p = lim;
      if (cs == 0) cs = 1;
      return int'(p) / cs;
    endfunction

    function void owe(logic [7:0] b);
      owed_byte.push_back(b);
      owed_last.push_back(1'b0);
    endfunction

    function void owe_decimal(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) owe(s[i]);
    endfunction

    // Work out the report for one accepted event and update tracking state.
    function void note_event(pointer_ev_t e);
      int unsigned col, row, code, bn;
      bit sgr, x10;
      sgr = mode[2];
      x10 = mode[3];
      if (e.cmd == CMD_NONE) return;
      col = pixel_to_cell(e.x, hborder, text_w, cell_w);
      row = pixel_to_cell(e.y, vborder, text_h, cell_h);
      bn = (e.bn == 0) ? 1 : e.bn;
      if (e.cmd == CMD_MOTION) begin
        if (col == last_col && row == last_row) return;
        if (!mode[0] && !mode[1]) return;
        if (mode[0] && held_code == CODE_NONE_HELD) return;
        code = held_code + 32;
        last_col = col;
        last_row = row;
      end else begin
        if (!sgr && e.cmd == CMD_RELEASE) begin
          code = 3;
        end else begin
          code = bn - 1;
          if (code >= 3) code += 61;
        end
        if (e.cmd == CMD_PRESS) begin
          held_code = code[6:0];
          last_col = col;
          last_row = row;
        end else begin
          // release always drops the held button, even when not reported
          held_code = CODE_NONE_HELD;
          if (x10) return;
          if (code == 64 || code == 65) return;
        end
      end
      if (!x10) begin
        if (e.sh) code += 4;
        if (e.su) code += 8;
        if (e.ct) code += 16;
      end
      if (sgr) begin
        owe(ESC_BYTE);
        owe("[");
        owe("<");
        owe_decimal(code);
        owe(";");
        owe_decimal(col + 1);
        owe(";");
        owe_decimal(row + 1);
        owe(e.cmd == CMD_RELEASE ? "m" : "M");
      end else if (col < 223 && row < 223) begin
        owe(ESC_BYTE);
        owe("[");
        owe("M");
        owe(8'(32 + code));
        owe(8'(33 + col));
        owe(8'(33 + row));
      end else begin
        return;
      end
      owed_last[$] = 1'b1;
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      logic [7:0] eb;
      logic       el;
      if (owed_byte.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected byte %02h last %0b", b, last);
        return;
      end
      eb = owed_byte.pop_front();
      el = owed_last.pop_front();
      if (b !== eb || last !== el) begin
        errors++;
        if (errors <= 10)
          $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                   eb, el, b, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mre_in_if  in_ch (clk);
  mre_out_if out_ch (clk);

  mouse_report_encoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  report_scoreboard sb = new();
  bit no_idle = 1'b0;     // set for phases that run both sides flat out
  bit hold_req = 1'b0;    // ask the receiver for one long hold-off
  bit rx_on = 1'b0;
  bit holding = 1'b0;     // stimulus side: a button is down

  // Write all seven registers back to back, then drop the enable.
  task automatic set_regs(logic [3:0] mode, int hb, int vb, int tw, int th, int cw, int ch);
    logic [CFG_DATA_W-1:0] vals[7];
    vals[0] = CFG_DATA_W'(mode);
    vals[1] = CFG_DATA_W'(hb);
    vals[2] = CFG_DATA_W'(vb);
    vals[3] = CFG_DATA_W'(tw);
    vals[4] = CFG_DATA_W'(th);
    vals[5] = CFG_DATA_W'(cw);
    vals[6] = CFG_DATA_W'(ch);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_INDEX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one event after a random gap; hold it until the block takes it.
  task automatic send_event(pointer_ev_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= e.cmd;
    in_ch.pointer_x <= e.x;
    in_ch.pointer_y <= e.y;
    in_ch.button_number <= e.bn;
    in_ch.shift_held <= e.sh;
    in_ch.super_held <= e.su;
    in_ch.control_held <= e.ct;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(e);
  endtask

  task automatic send(logic [1:0] cmd, int x, int y, logic [3:0] bn, logic [2:0] mods);
    pointer_ev_t e;
    e.cmd = cmd;
    e.x = 16'(x);
    e.y = 16'(y);
    e.bn = bn;
    {e.ct, e.su, e.sh} = mods;
    send_event(e);
  endtask

  // Wait for every owed byte, then let in-flight silent events finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed_byte.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Random position around the text area, now and then anywhere.
  function automatic int rand_pos(int border, int limit);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
    return border - 8 + int'($urandom_range(0, limit + 16));
  endfunction

  // Mostly press / drag / release sequences, with some noise mixed in.
  task automatic send_random();
    int r;
    logic [1:0] cmd;
    logic [3:0] bn;
    r = $urandom_range(0, 99);
    if (r < 5) cmd = CMD_NONE;
    else if (!holding) cmd = (r < 80) ? CMD_PRESS : (r < 90 ? CMD_MOTION : CMD_RELEASE);
    else cmd = (r < 60) ? CMD_MOTION : (r < 88 ? CMD_RELEASE : CMD_PRESS);
    if (cmd == CMD_PRESS) holding = 1'b1;
    if (cmd == CMD_RELEASE) holding = 1'b0;
    bn = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
    send(cmd, rand_pos(sb.hborder, sb.text_w), rand_pos(sb.vborder, sb.text_h), bn,
         3'($urandom_range(0, 7)));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int st;
    out_ch.ready = 1'b0;
    wait (rx_on);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      st = no_idle ? 0 : $urandom_range(0, 13);
      if (st > 0) begin
        out_ch.ready <= 1'b0;
        repeat (st) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_byte(out_ch.report_byte, out_ch.last_byte);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("** mouse_report_encoder_unit: FAILED **");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.pointer_x = '0;
    in_ch.pointer_y = '0;
    in_ch.button_number = '0;
    in_ch.shift_held = 1'b0;
    in_ch.super_held = 1'b0;
    in_ch.control_held = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rx_on = 1'b1;

    // SGR with button-motion: clicks, drags, wheel, extremes of every field.
    set_regs(4'b0101, 2, 2, 640, 480, 8, 16);
    send(CMD_PRESS, 10, 20, 4'd1, 3'b000);
    send(CMD_MOTION, 11, 21, 4'd1, 3'b000);     // same cell: silent
    send(CMD_MOTION, 100, 200, 4'd1, 3'b001);
    send(CMD_RELEASE, 100, 200, 4'd1, 3'b000);
    send(CMD_MOTION, 300, 300, 4'd1, 3'b000);   // nothing held: silent
    send(CMD_PRESS, 50, 50, 4'd0, 3'b010);      // button zero acts as first button
    send(CMD_RELEASE, 50, 50, 4'd0, 3'b100);
    send(CMD_PRESS, 60, 60, 4'd4, 3'b000);      // wheel up
    send(CMD_RELEASE, 60, 60, 4'd4, 3'b000);    // wheel release: dropped
    send(CMD_PRESS, 32767, 32767, 4'd15, 3'b111);
    send(CMD_RELEASE, 32767, 32767, 4'd15, 3'b111);
    send(CMD_PRESS, -32768, -32768, 4'd2, 3'b001);
    send(CMD_NONE, 400, 400, 4'd3, 3'b111);     // unused command: ignored
    send(CMD_MOTION, 500, 400, 4'd2, 3'b000);
    send(CMD_RELEASE, 500, 400, 4'd5, 3'b000);
    drain();

    // Legacy form, one pixel cells: far cell cutoff and release code.
    set_regs(4'b0000, 0, 0, 16383, 16383, 1, 1);
    send(CMD_PRESS, 222, 0, 4'd1, 3'b000);
    send(CMD_PRESS, 223, 5, 4'd3, 3'b000);      // past the legacy range
    send(CMD_RELEASE, 5, 222, 4'd3, 3'b011);
    send(CMD_MOTION, 9, 9, 4'd1, 3'b000);       // motion off: silent
    drain();

    // X10 with any-motion: modifiers ignored, releases silent.
    set_regs(4'b1010, 2, 2, 640, 480, 8, 16);
    send(CMD_PRESS, 40, 40, 4'd1, 3'b111);
    send(CMD_RELEASE, 40, 40, 4'd1, 3'b000);
    send(CMD_MOTION, 200, 200, 4'd1, 3'b111);
    drain();

    // Zero text and cell sizes, widest borders, every mode bit set.
    set_regs(4'b1111, 4095, 4095, 0, 0, 0, 0);
    send(CMD_PRESS, 5000, 5000, 4'd3, 3'b000);
    send(CMD_MOTION, 9000, 100, 4'd3, 3'b000);
    send(CMD_RELEASE, 5000, 5000, 4'd3, 3'b000);
    drain();

    // Random phases with random settings.
    for (int ph = 0; ph < 7; ph++) begin
      int tw, th;
      tw = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16383) : $urandom_range(64, 1200);
      th = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16383) : $urandom_range(64, 900);
      set_regs(ph == 0 ? 4'b0101 : 4'($urandom_range(0, 15)),
               ph == 3 ? 4095 : $urandom_range(0, 40),
               ph == 3 ? 4095 : $urandom_range(0, 40),
               tw, th,
               ph == 4 ? 255 : $urandom_range(1, 24),
               ph == 4 ? 255 : $urandom_range(1, 32));
      no_idle = (ph == 2);
      if (ph == 1) hold_req = 1'b1;  // stall output while events keep coming
      holding = 1'b0;
      repeat (20) send_random();
      drain();
    end
    no_idle = 1'b0;

    if (sb.errors == 0 && sb.owed_byte.size() == 0) begin
      $display("** mouse_report_encoder_unit: PASSED **");
    end else begin
      $display("** mouse_report_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
